// ===== design/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

    // envelope scaling and duration widths
    localparam int LEVEL_BITS = 15;
    localparam int DUR_BITS   = 24;

    localparam int LVL_W  = LEVEL_BITS + 1;   // level incl. full scale
    localparam int DUR_W  = DUR_BITS;
    localparam int TIME_W = 32;
    localparam int SUS_W  = 16;
    localparam int LEV_W  = 16;               // level port width
    localparam int CMP_W  = TIME_W + 1;
    localparam int PROD_W = LVL_W + DUR_W;    // numerator width
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    localparam logic [LVL_W-1:0] FULL = {1'b1, {LEVEL_BITS{1'b0}}};

    // input reg, segment select, multiply, one stage per quotient bit, output reg
    localparam int LATENCY = LVL_W + 4;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_ONSET   = 3'd0;
    localparam logic [2:0] REG_NOTE    = 3'd1;
    localparam logic [2:0] REG_ATTACK  = 3'd2;
    localparam logic [2:0] REG_DECAY   = 3'd3;
    localparam logic [2:0] REG_SUSTAIN = 3'd4;
    localparam logic [2:0] REG_RELEASE = 3'd5;

endpackage

`default_nettype wire

// ===== design/adsr_envelope_level_unit.sv =====
`default_nettype none

// Linear ADSR envelope level. Each item is a time stamp in sample ticks; the
// block returns the envelope level at that time (32768 = 1.0) on o_level with
// o_done high for one cycle. A new item may be taken every cycle: busy is
// never raised, and the results come out in order with no gaps other than
// those of the input. The pipe holds the input register, the segment select,
// the multiplier, the divider, which resolves one quotient bit per pipeline
// stage (16 stages), and the output register. The receiver cannot stall, so
// nothing in the pipe ever waits.
// Configuration goes through the APB port at byte addresses 0 (onset),
// 4 (note length), 8 (attack), 12 (decay), 16 (sustain), 20 (release) and
// must only be changed while no item is in flight.

module adsr_envelope_level_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // item channel
    input  wire                        start,
    output logic                       busy,
    input  wire [adsr_pkg::TIME_W-1:0] i_time_now,
    output logic                       o_done,
    output logic [adsr_pkg::LEV_W-1:0] o_level,
    // apb configuration port
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [adsr_pkg::ADDR_W-1:0] paddr,
    input  wire [adsr_pkg::DATA_W-1:0] pwdata,
    output logic [adsr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    import adsr_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] r_onset;
    logic [DUR_W-1:0]  r_note;
    logic [DUR_W-1:0]  r_attack;
    logic [DUR_W-1:0]  r_decay;
    logic [SUS_W-1:0]  r_sustain;
    logic [DUR_W-1:0]  r_release;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_onset   <= '0;
            r_note    <= '0;
            r_attack  <= '0;
            r_decay   <= '0;
            r_sustain <= '0;
            r_release <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ONSET:   r_onset   <= pwdata[TIME_W-1:0];
                REG_NOTE:    r_note    <= pwdata[DUR_W-1:0];
                REG_ATTACK:  r_attack  <= pwdata[DUR_W-1:0];
                REG_DECAY:   r_decay   <= pwdata[DUR_W-1:0];
                REG_SUSTAIN: r_sustain <= pwdata[SUS_W-1:0];
                REG_RELEASE: r_release <= pwdata[DUR_W-1:0];
                default: ;  // writes past the last register are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ONSET:   prdata = DATA_W'(r_onset);
            REG_NOTE:    prdata = DATA_W'(r_note);
            REG_ATTACK:  prdata = DATA_W'(r_attack);
            REG_DECAY:   prdata = DATA_W'(r_decay);
            REG_SUSTAIN: prdata = DATA_W'(r_sustain);
            REG_RELEASE: prdata = DATA_W'(r_release);
            default:     prdata = '0;
        endcase
    end

    // the pipe never holds, so an item is always welcome
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: elapsed time; the borrow tells an item before the onset
    // ------------------------------------------------------------------
    logic [TIME_W:0]   n_elapsed;
    logic              r_s1_vld;
    logic              r_s1_early;
    logic [TIME_W-1:0] r_s1_e;

    assign n_elapsed = {1'b0, i_time_now} - {1'b0, r_onset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start & ~busy;
        end
        r_s1_early <= n_elapsed[TIME_W];
        r_s1_e     <= n_elapsed[TIME_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage 2: pick the segment and set up level = base +/- m * x / d
    // segments without a ramp use m = 0 and d = 1, which gives q = 0
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] s_eff;
    logic [CMP_W-1:0] e_ext;
    logic [CMP_W-1:0] end_attack;
    logic [CMP_W-1:0] end_decay;
    logic [CMP_W-1:0] end_note;
    logic [CMP_W-1:0] end_release;
    logic [DUR_W-1:0] x_attack;
    logic [DUR_W-1:0] x_decay;
    logic [DUR_W-1:0] x_release;

    logic [LVL_W-1:0] n_mul;
    logic [DUR_W-1:0] n_x;
    logic [DUR_W-1:0] n_div;
    logic [LVL_W-1:0] n_base;
    logic             n_sub;

    logic             r_s2_vld;
    logic [LVL_W-1:0] r_s2_mul;
    logic [DUR_W-1:0] r_s2_x;
    logic [DUR_W-1:0] r_s2_div;
    logic [LVL_W-1:0] r_s2_base;
    logic             r_s2_sub;

    // sustain above full scale saturates
    assign s_eff = (TIME_W'(r_sustain) > TIME_W'(FULL)) ? FULL : LVL_W'(r_sustain);

    assign e_ext       = {1'b0, r_s1_e};
    assign end_attack  = CMP_W'(r_attack);
    assign end_decay   = CMP_W'(r_attack) + CMP_W'(r_decay);
    assign end_note    = CMP_W'(r_note);
    assign end_release = CMP_W'(r_note) + CMP_W'(r_release);

    // offsets into a segment stay below its length when that segment is taken
    assign x_attack  = r_s1_e[DUR_W-1:0];
    assign x_decay   = r_s1_e[DUR_W-1:0] - r_attack;
    assign x_release = r_s1_e[DUR_W-1:0] - r_note;

    always_comb begin
        n_mul  = '0;
        n_x    = '0;
        n_div  = DUR_W'(1);
        n_base = '0;
        n_sub  = 1'b0;
        if (r_s1_early) begin
            n_base = '0;
        end else if (e_ext < end_attack) begin
            n_mul = FULL;
            n_x   = x_attack;
            n_div = r_attack;
        end else if (e_ext < end_decay) begin
            n_mul  = FULL - s_eff;
            n_x    = x_decay;
            n_div  = r_decay;
            n_base = FULL;
            n_sub  = 1'b1;
        end else if (e_ext < end_note) begin
            n_base = s_eff;
        end else if (e_ext < end_release) begin
            n_mul  = s_eff;
            n_x    = x_release;
            n_div  = r_release;
            n_base = s_eff;
            n_sub  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_mul  <= n_mul;
        r_s2_x    <= n_x;
        r_s2_div  <= n_div;
        r_s2_base <= n_base;
        r_s2_sub  <= n_sub;
    end

    // ------------------------------------------------------------------
    // stage 3: numerator product, split for the divider
    // since x < d the upper part already sits below the divisor
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] n_prod;

    logic             r_dv_vld  [0:LVL_W];
    logic [DUR_W-1:0] r_dv_rem  [0:LVL_W];
    logic [LVL_W-1:0] r_dv_nq   [0:LVL_W];
    logic [DUR_W-1:0] r_dv_div  [0:LVL_W];
    logic [LVL_W-1:0] r_dv_base [0:LVL_W];
    logic             r_dv_sub  [0:LVL_W];

    assign n_prod = PROD_W'(r_s2_mul) * PROD_W'(r_s2_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_s2_vld;
        end
        r_dv_rem[0]  <= n_prod[PROD_W-1:LVL_W];
        r_dv_nq[0]   <= n_prod[LVL_W-1:0];
        r_dv_div[0]  <= r_s2_div;
        r_dv_base[0] <= r_s2_base;
        r_dv_sub[0]  <= r_s2_sub;
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // nq shifts numerator bits out at the top and quotient bits in below
    // ------------------------------------------------------------------
    for (genvar k = 0; k < LVL_W; k++) begin : g_div
        logic [DUR_W:0] trial;
        logic [DUR_W:0] diff;
        logic           fit;

        assign trial = {r_dv_rem[k], r_dv_nq[k][LVL_W-1]};
        assign diff  = trial - {1'b0, r_dv_div[k]};
        assign fit   = ~diff[DUR_W] | trial[DUR_W];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            r_dv_rem[k+1]  <= fit ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            r_dv_nq[k+1]   <= {r_dv_nq[k][LVL_W-2:0], fit};
            r_dv_div[k+1]  <= r_dv_div[k];
            r_dv_base[k+1] <= r_dv_base[k];
            r_dv_sub[k+1]  <= r_dv_sub[k];
        end
    end

    // ------------------------------------------------------------------
    // output register: apply the ramp to the segment base
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] n_level;
    logic             r_done;
    logic [LVL_W-1:0] r_level;

    assign n_level = r_dv_sub[LVL_W] ? r_dv_base[LVL_W] - r_dv_nq[LVL_W]
                                     : r_dv_base[LVL_W] + r_dv_nq[LVL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv_vld[LVL_W];
        end
        r_level <= n_level;
    end

    assign o_done  = r_done;
    assign o_level = LEV_W'(r_level);

`ifndef SYNTHESIS
    // every accepted item comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("item lost in the pipe");

    // no result without an item taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without an item");

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[LVL_W] |-> (r_dv_rem[LVL_W] < r_dv_div[LVL_W]))
        else $error("divider remainder out of range");

    // level never exceeds full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_level <= FULL))
        else $error("level above full scale");
`endif

endmodule

`default_nettype wire

// ===== tb/adsr_envelope_level_unit_test.sv =====
`default_nettype none

// envelope level unit check: time stamps go in through the start/busy
// handshake, levels come back on o_level with o_done, and every level is
// compared in order against a local computation of the envelope

module adsr_envelope_level_unit_test;

    import adsr_pkg::*;

    // spare register slots, writes there must change nothing
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_SETS  = 8;
    localparam int ITEMS_PER_SET = 50;

    // own copy of the envelope registers and the levels still owed by the unit
    class envelope_tracker;
        bit [TIME_W-1:0] onset_tick;
        bit [DUR_W-1:0]  note_ticks;
        bit [DUR_W-1:0]  attack_ticks;
        bit [DUR_W-1:0]  decay_ticks;
        bit [SUS_W-1:0]  sustain_raw;
        bit [DUR_W-1:0]  release_ticks;
        bit [LEV_W-1:0]  levels_due[$];
        int              mismatches;
        int              levels_checked;

        function void set_register(bit [2:0] idx, bit [DATA_W-1:0] value);
            case (idx)
                REG_ONSET:   onset_tick    = value[TIME_W-1:0];
                REG_NOTE:    note_ticks    = value[DUR_W-1:0];
                REG_ATTACK:  attack_ticks  = value[DUR_W-1:0];
                REG_DECAY:   decay_ticks   = value[DUR_W-1:0];
                REG_SUSTAIN: sustain_raw   = value[SUS_W-1:0];
                REG_RELEASE: release_ticks = value[DUR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [LEV_W-1:0] level_at(bit [TIME_W-1:0] now);
            bit [63:0] full;
            bit [63:0] e;
            bit [63:0] s;
            bit [63:0] a;
            bit [63:0] d;
            bit [63:0] len;
            bit [63:0] r;
            bit [63:0] lvl;
            full = 64'd1 << LEVEL_BITS;
            a    = attack_ticks;
            d    = decay_ticks;
            len  = note_ticks;
            r    = release_ticks;
            s    = (sustain_raw > full) ? full : sustain_raw;
            if (now < onset_tick) begin
                lvl = 0;
            end else begin
                e = now - onset_tick;
                // zero-length segments fall through, so no divide by zero
                if (e < a) begin
                    lvl = (e * full) / a;
                end else if (e < a + d) begin
                    lvl = full - ((full - s) * (e - a)) / d;
                end else if (e < len) begin
                    lvl = s;
                end else if (e < len + r) begin
                    lvl = s - (s * (e - len)) / r;
                end else begin
                    lvl = 0;
                end
            end
            return lvl[LEV_W-1:0];
        endfunction

        function void take_time_stamp(bit [TIME_W-1:0] now);
            levels_due.push_back(level_at(now));
        endfunction

        function void compare_level(logic [LEV_W-1:0] got);
            bit [LEV_W-1:0] want;
            if (levels_due.size() == 0) begin
                $error("level: result with nothing pending, expected none, actual %0d", got);
                mismatches++;
                return;
            end
            want = levels_due.pop_front();
            levels_checked++;
            if (got !== want) begin
                $error("level: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return levels_due.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [TIME_W-1:0]   i_time_now;
    logic                o_done;
    logic [LEV_W-1:0]    o_level;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    envelope_tracker     book;
    int                  cycle_count = 0;
    int                  stamps_sent = 0;
    int                  settings_used = 0;

    adsr_envelope_level_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_time_now (i_time_now),
        .o_done     (o_done),
        .o_level    (o_level),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 8-unit clock period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // a level is taken at the edge that ends its o_done cycle, the receiver never stalls
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            book.compare_level(o_level);
        end
    end

    // watchdog, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d levels outstanding",
                     cycle_count, book.outstanding());
            $display("Regression FAIL");
            $finish;
        end
    end

    // one item: hold start until the unit takes it, then maybe leave a gap
    task automatic send_time(input bit [TIME_W-1:0] stamp, input int idle_pct);
        start      <= 1'b1;
        i_time_now <= stamp;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        book.take_time_stamp(stamp);
        stamps_sent++;
        // each following cycle is idle with the given chance
        while ($urandom_range(0, 99) < idle_pct) begin
            // scramble the data bus while start is low, it must be ignored
            start      <= 1'b0;
            i_time_now <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // stop sending and let every level owed come back
    task automatic drain_levels();
        start <= 1'b0;
        @(posedge i_clk);
        while (book.outstanding() != 0) @(posedge i_clk);
    endtask

    // setup then access phase; psel stays up so writes can run back to back
    task automatic write_reg(input bit [2:0] idx, input bit [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        book.set_register(idx, value);
    endtask

    // full envelope setting, only called with nothing in flight
    task automatic apply_setting(input bit [DATA_W-1:0] onset, input bit [DATA_W-1:0] note,
                                 input bit [DATA_W-1:0] atk, input bit [DATA_W-1:0] dec,
                                 input bit [DATA_W-1:0] sus, input bit [DATA_W-1:0] rel,
                                 input bit spare);
        write_reg(REG_ONSET, onset);
        write_reg(REG_NOTE, note);
        write_reg(REG_ATTACK, atk);
        write_reg(REG_DECAY, dec);
        write_reg(REG_SUSTAIN, sus);
        write_reg(REG_RELEASE, rel);
        if (spare) begin
            // out of range slots, the setting must not move
            write_reg(REG_SPARE_LO, $urandom);
            write_reg(REG_SPARE_HI, $urandom);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    // duration with junk above bit 23, mostly short so all segments get hit
    function automatic bit [DATA_W-1:0] pick_duration();
        bit [7:0]       junk;
        bit [DUR_W-1:0] dur;
        junk = 8'($urandom);
        case ($urandom_range(0, 9))
            0:       dur = '0;
            1:       dur = '1;
            2:       dur = DUR_W'($urandom);
            3, 4:    dur = DUR_W'($urandom_range(1, 4096));
            default: dur = DUR_W'($urandom_range(1, 64));
        endcase
        return {junk, dur};
    endfunction

    function automatic bit [DATA_W-1:0] pick_sustain();
        bit [15:0] junk;
        bit [15:0] lvl;
        junk = 16'($urandom);
        case ($urandom_range(0, 5))
            0:       lvl = '0;
            1:       lvl = 16'd32768;
            2:       lvl = 16'($urandom_range(32769, 65535));   // saturates to full scale
            default: lvl = 16'($urandom_range(1, 32767));
        endcase
        return {junk, lvl};
    endfunction

    function automatic bit [DATA_W-1:0] pick_onset();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return $urandom_range(0, 2000);
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 2000);
            default: return $urandom_range(0, 100000);
        endcase
    endfunction

    // time stamps aimed at the current envelope: inside it, on segment
    // edges, just before onset, and anywhere in the 32-bit range
    task automatic send_random_times(input int count, input int idle_pct);
        bit [TIME_W-1:0] span;
        bit [TIME_W-1:0] base;
        bit [TIME_W-1:0] stamp;
        int              k;
        for (k = 0; k < count; k++) begin
            span = book.note_ticks + book.attack_ticks + book.decay_ticks
                 + book.release_ticks + 8;
            case ($urandom_range(0, 9))
                0, 1: stamp = $urandom;
                2: begin
                    stamp = book.onset_tick - $urandom_range(1, 100);
                end
                3: begin
                    case ($urandom_range(0, 3))
                        0:       base = book.attack_ticks;
                        1:       base = book.attack_ticks + book.decay_ticks;
                        2:       base = book.note_ticks;
                        default: base = book.note_ticks + book.release_ticks;
                    endcase
                    stamp = book.onset_tick + base + $urandom_range(0, 2) - 1;
                end
                default: stamp = book.onset_tick + $urandom_range(0, span);
            endcase
            send_time(stamp, idle_pct);
        end
    endtask

    initial begin
        int set_idx;
        int idle_pct;

        book = new();
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_time_now <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: every duration zero, so the level is zero everywhere
        send_time(32'h0, 16);
        send_time(32'hFFFF_FFFF, 16);
        drain_levels();

        // ordinary note: before onset, attack, decay, sustain, release, after
        apply_setting(32'd1000, 32'd400, 32'd100, 32'd50, 32'd20000, 32'd200, 1'b0);
        send_time(32'd999, 16);
        send_time(32'd1000, 16);
        send_time(32'd1050, 16);
        send_time(32'd1100, 16);
        send_time(32'd1125, 16);
        send_time(32'd1150, 16);
        send_time(32'd1399, 16);
        send_time(32'd1400, 16);
        send_time(32'd1599, 16);
        send_time(32'd1600, 16);
        drain_levels();

        // note ends inside attack, sustain above full scale
        apply_setting(32'd0, 32'd5, 32'd10, 32'd10, 32'h0000_FFFF, 32'd20, 1'b0);
        send_time(32'd5, 16);
        send_time(32'd19, 16);
        send_time(32'd20, 16);
        send_time(32'd24, 16);
        send_time(32'd25, 16);
        drain_levels();

        // every segment zero length, plus writes to the spare slots
        apply_setting(32'd7, 32'd0, 32'd0, 32'd0, 32'd32768, 32'd0, 1'b1);
        send_time(32'd7, 16);
        send_time(32'd6, 16);
        drain_levels();

        // onset at the top of the time range, longest segments
        apply_setting(32'hFFFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
                      32'd32768, 32'hFF_FFFF, 1'b0);
        send_time(32'hFFFF_FFFF, 16);
        send_time(32'hFFFF_FFFE, 16);
        drain_levels();

        // longest segments from zero with silent sustain
        apply_setting(32'd0, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'hFF_FFFF, 1'b0);
        send_time(32'h00FF_FFFE, 16);
        send_time(32'h01FF_FFFD, 16);
        send_time(32'h01FF_FFFE, 16);
        drain_levels();

        // random envelopes; sender gaps light, then heavy, then none
        for (set_idx = 0; set_idx < RANDOM_SETS; set_idx++) begin
            idle_pct = (set_idx < 3) ? 16 : (set_idx < 6) ? 57 : 0;
            apply_setting(pick_onset(), pick_duration(), pick_duration(), pick_duration(),
                          pick_sustain(), pick_duration(), $urandom_range(0, 3) == 0);
            send_random_times(ITEMS_PER_SET, idle_pct);
            drain_levels();
        end

        // trailing window for any stray o_done
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("%0d time stamps sent, %0d levels checked over %0d envelope settings",
                 stamps_sent, book.levels_checked, settings_used);
        $display("reset values, segment edges, zero-length and saturated cases, random envelopes");
        if (book.mismatches == 0 && book.outstanding() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
